// ===== rtl/core/cat_pkg.sv =====
// Package for the command argument tokenizer.
// Holds scan modes, token kinds, error codes, character classes and state types.
// No dependencies.
package cat_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 31;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_STRING = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_WORD   = 3'd3,
        MODE_SKIP   = 3'd4
    } t_mode;

    localparam logic [1:0] KIND_STRING = 2'd0;
    localparam logic [1:0] KIND_INT    = 2'd1;
    localparam logic [1:0] KIND_BOOL   = 2'd2;
    localparam logic [1:0] KIND_OPTION = 2'd3;

    localparam logic [2:0] ERR_UNEXPECTED   = 3'd0;
    localparam logic [2:0] ERR_TWO_PERIODS  = 3'd1;
    localparam logic [2:0] ERR_BAD_DIGIT    = 3'd2;
    localparam logic [2:0] ERR_FLOAT        = 3'd3;
    localparam logic [2:0] ERR_UNTERMINATED = 3'd4;
    localparam logic [2:0] ERR_OVERFLOW     = 3'd5;

    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_PERIOD    = 8'h2E;

    localparam logic [2:0] LEN_TRUE  = 3'd4;
    localparam logic [2:0] LEN_FALSE = 3'd5;
    localparam logic [2:0] POS_MAX   = 3'd7;

    typedef struct packed {
        t_mode      mode;
        logic       quote_single;
        logic       escape;
        logic       period;
        logic       overflow;
        logic [2:0] pos;
        logic [1:0] which;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        mode: MODE_IDLE, quote_single: 1'b0, escape: 1'b0, period: 1'b0,
        overflow: 1'b0, pos: 3'd0, which: 2'b11
    };

    typedef struct packed {
        logic       has_byte;
        logic [7:0] content_byte;
        logic       token_done;
        logic [1:0] token_kind;
        logic       bool_value;
        logic       error_flag;
        logic [2:0] error_code;
        logic       line_done;
    } t_result;

    function automatic logic f_is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic f_is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic [7:0] f_true_char(input logic [2:0] p);
        logic [7:0] r;
        unique case (p)
            3'd0:    r = 8'h74;
            3'd1:    r = 8'h72;
            3'd2:    r = 8'h75;
            3'd3:    r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] f_false_char(input logic [2:0] p);
        logic [7:0] r;
        unique case (p)
            3'd0:    r = 8'h66;
            3'd1:    r = 8'h61;
            3'd2:    r = 8'h6C;
            3'd3:    r = 8'h73;
            3'd4:    r = 8'h65;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/cat_if.sv =====
// Handshake channels of the command argument tokenizer.
// cat_char_if carries characters in, cat_tok_if carries token results out.
// No dependencies.
interface cat_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_end;

    modport source (output valid, output char_in, output line_end, input ready);
    modport sink (input valid, input char_in, input line_end, output ready);
endinterface

interface cat_tok_if #(
    parameter int VALUE_WIDTH = 31
);
    logic                   valid;
    logic                   ready;
    logic                   has_byte;
    logic [7:0]             content_byte;
    logic                   token_done;
    logic [1:0]             token_kind;
    logic [VALUE_WIDTH-1:0] int_value;
    logic                   bool_value;
    logic                   error_flag;
    logic [2:0]             error_code;
    logic                   line_done;

    modport source (
        output valid, output has_byte, output content_byte, output token_done,
        output token_kind, output int_value, output bool_value, output error_flag,
        output error_code, output line_done, input ready
    );
    modport sink (
        input valid, input has_byte, input content_byte, input token_done,
        input token_kind, input int_value, input bool_value, input error_flag,
        input error_code, input line_done, output ready
    );
endinterface

// ===== rtl/core/cat_step.sv =====
// Per-character scan logic: next scan state and one result from one character.
// Depends on cat_pkg.
module cat_step #(
    parameter int VALUE_WIDTH = cat_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic [7:0]             i_char,
    input  logic                   i_last,
    input  cat_pkg::t_scan_state   i_st,
    input  logic [VALUE_WIDTH-1:0] i_accum,
    output cat_pkg::t_scan_state   o_st,
    output logic [VALUE_WIDTH-1:0] o_accum,
    output cat_pkg::t_result       o_res,
    output logic [VALUE_WIDTH-1:0] o_int
);
    import cat_pkg::*;

    localparam int PW = VALUE_WIDTH + 4;

    t_scan_state            st;
    logic [VALUE_WIDTH-1:0] acc;
    t_result                res;
    logic [VALUE_WIDTH-1:0] ival;
    logic                   do_num;
    logic                   do_word;
    logic                   num_end;
    logic                   word_end;
    logic                   sp;
    logic [PW-1:0]          prod;
    logic [7:0]             quote;

    always_comb begin
        st       = i_st;
        acc      = i_accum;
        res      = '0;
        ival     = '0;
        do_num   = 1'b0;
        do_word  = 1'b0;
        num_end  = 1'b0;
        word_end = 1'b0;
        sp       = f_is_space(i_char);
        quote    = i_st.quote_single ? CH_SQUOTE : CH_DQUOTE;
        prod     = ({4'b0, i_accum} << 3) + ({4'b0, i_accum} << 1) + PW'(i_char[3:0]);

        unique case (i_st.mode)
            MODE_STRING: begin
                if (i_st.escape) begin
                    st.escape        = 1'b0;
                    res.has_byte     = 1'b1;
                    res.content_byte = i_char;
                end else if (i_char == CH_BACKSLASH) begin
                    st.escape = 1'b1;
                end else if (i_char == quote) begin
                    res.token_done = 1'b1;
                    res.token_kind = KIND_STRING;
                    st.mode        = MODE_IDLE;
                end else begin
                    res.has_byte     = 1'b1;
                    res.content_byte = i_char;
                end
            end
            MODE_NUMBER: do_num = 1'b1;
            MODE_WORD: begin
                if (sp) begin
                    word_end = 1'b1;
                end else begin
                    do_word = 1'b1;
                end
            end
            MODE_SKIP: ;
            MODE_IDLE: begin
                if (sp) begin
                end else if (i_char == CH_DQUOTE || i_char == CH_SQUOTE) begin
                    st.mode         = MODE_STRING;
                    st.quote_single = (i_char == CH_SQUOTE);
                    st.escape       = 1'b0;
                end else if (f_is_digit(i_char) || i_char == CH_PERIOD) begin
                    st.mode     = MODE_NUMBER;
                    acc         = '0;
                    prod        = PW'(i_char[3:0]);
                    st.period   = 1'b0;
                    st.overflow = 1'b0;
                    do_num      = 1'b1;
                end else if (f_is_alpha(i_char)) begin
                    st.mode  = MODE_WORD;
                    st.pos   = 3'd0;
                    st.which = 2'b11;
                    do_word  = 1'b1;
                end else begin
                    res.error_flag = 1'b1;
                    res.error_code = ERR_UNEXPECTED;
                    st.mode        = MODE_SKIP;
                end
            end
            default: st.mode = MODE_IDLE;
        endcase

        if (do_num) begin
            priority if (i_char == CH_PERIOD) begin
                if (st.period) begin
                    res.error_flag = 1'b1;
                    res.error_code = ERR_TWO_PERIODS;
                    st.mode        = MODE_SKIP;
                end else begin
                    st.period = 1'b1;
                end
            end else if (sp) begin
                num_end = 1'b1;
            end else if (f_is_digit(i_char)) begin
                if (prod[PW-1:VALUE_WIDTH] != '0) begin
                    st.overflow = 1'b1;
                    acc         = '1;
                end else begin
                    acc = prod[VALUE_WIDTH-1:0];
                end
            end else begin
                res.error_flag = 1'b1;
                res.error_code = ERR_BAD_DIGIT;
                st.mode        = MODE_SKIP;
            end
        end

        if (do_word) begin
            res.has_byte     = 1'b1;
            res.content_byte = i_char;
            if (!(st.pos < LEN_TRUE && i_char == f_true_char(st.pos))) begin
                st.which[0] = 1'b0;
            end
            if (!(st.pos < LEN_FALSE && i_char == f_false_char(st.pos))) begin
                st.which[1] = 1'b0;
            end
            if (st.pos < POS_MAX) begin
                st.pos = st.pos + 3'd1;
            end
        end

        if (num_end || (i_last && st.mode == MODE_NUMBER)) begin
            priority if (st.period) begin
                res            = '0;
                res.error_flag = 1'b1;
                res.error_code = ERR_FLOAT;
                st.mode        = MODE_SKIP;
            end else if (st.overflow) begin
                res            = '0;
                res.error_flag = 1'b1;
                res.error_code = ERR_OVERFLOW;
                st.mode        = MODE_SKIP;
            end else begin
                res.token_done = 1'b1;
                res.token_kind = KIND_INT;
                ival           = acc;
                st.mode        = MODE_IDLE;
            end
        end

        if (word_end || (i_last && st.mode == MODE_WORD)) begin
            res.token_done = 1'b1;
            st.mode        = MODE_IDLE;
            priority if (st.which[0] && st.pos == LEN_TRUE) begin
                res.token_kind = KIND_BOOL;
                res.bool_value = 1'b1;
            end else if (st.which[1] && st.pos == LEN_FALSE) begin
                res.token_kind = KIND_BOOL;
            end else begin
                res.token_kind = KIND_OPTION;
            end
        end

        if (i_last && st.mode == MODE_STRING) begin
            res            = '0;
            res.error_flag = 1'b1;
            res.error_code = ERR_UNTERMINATED;
            ival           = '0;
        end

        if (i_last) begin
            res.line_done = 1'b1;
            st            = SCAN_RESET;
            acc           = '0;
        end
    end

    assign o_st    = st;
    assign o_accum = acc;
    assign o_res   = res;
    assign o_int   = ival;

endmodule

// ===== rtl/core/command_argument_tokenizer.sv =====
// Top level of the command argument tokenizer: scan state, result register.
// Depends on cat_pkg, cat_if (cat_char_if, cat_tok_if) and cat_step.
//
//  port    | dir | item                  | handshake
//  i_cmd   | in  | char_in, line_end     | valid/ready
//  o_tok   | out | token result fields   | valid/ready
//
// One character per cycle while o_tok takes results; the result is registered, in the cycle after acceptance.
// Throughput is set by the single result register: it refills while being taken.
// A stall on o_tok holds the result and drops i_cmd.ready until it is taken.
// Synchronous active-low reset clears the scan state and the result valid.
module command_argument_tokenizer #(
    parameter int VALUE_WIDTH = cat_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cat_char_if.sink    i_cmd,
    cat_tok_if.source   o_tok
);
    import cat_pkg::*;

    t_scan_state            r_st;
    logic [VALUE_WIDTH-1:0] r_accum;
    t_result                r_res;
    logic [VALUE_WIDTH-1:0] r_int;
    logic                   r_out_valid;

    t_scan_state            n_st;
    logic [VALUE_WIDTH-1:0] n_accum;
    t_result                n_res;
    logic [VALUE_WIDTH-1:0] n_int;
    logic                   in_acc;

    cat_step #(.VALUE_WIDTH(VALUE_WIDTH)) u_step (
        .i_char  (i_cmd.char_in),
        .i_last  (i_cmd.line_end),
        .i_st    (r_st),
        .i_accum (r_accum),
        .o_st    (n_st),
        .o_accum (n_accum),
        .o_res   (n_res),
        .o_int   (n_int)
    );

    assign i_cmd.ready = !r_out_valid || o_tok.ready;
    assign in_acc      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= SCAN_RESET;
            r_accum     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_st        <= n_st;
                r_accum     <= n_accum;
                r_out_valid <= 1'b1;
            end else if (o_tok.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= n_res;
            r_int <= n_int;
        end
    end

    assign o_tok.valid        = r_out_valid;
    assign o_tok.has_byte     = r_res.has_byte;
    assign o_tok.content_byte = r_res.content_byte;
    assign o_tok.token_done   = r_res.token_done;
    assign o_tok.token_kind   = r_res.token_kind;
    assign o_tok.int_value    = r_int;
    assign o_tok.bool_value   = r_res.bool_value;
    assign o_tok.error_flag   = r_res.error_flag;
    assign o_tok.error_code   = r_res.error_code;
    assign o_tok.line_done    = r_res.line_done;

    a_line_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_cmd.line_end) |=> (r_st.mode == MODE_IDLE && r_accum == '0))
        else $error("scan state not cleared after line end");

    a_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.error_flag) |-> (!o_tok.token_done && !o_tok.has_byte))
        else $error("error result carries token data");

    a_int_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tok.valid && o_tok.int_value != '0) |->
            (o_tok.token_done && o_tok.token_kind == KIND_INT))
        else $error("integer value outside an integer token");

    a_skip_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_st.mode == MODE_SKIP) |=>
            (!o_tok.has_byte && !o_tok.token_done && !o_tok.error_flag))
        else $error("result produced while skipping after error");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_tok.valid)
        else $error("accepted item has no result");

endmodule

// ===== dv/command_argument_tokenizer_checker.sv =====
`timescale 1ns / 1ps
// Checker for the command argument tokenizer: predicts one token result per accepted
// character and compares it with each accepted result, in order.
// Depends on cat_pkg and the channel interfaces cat_char_if and cat_tok_if.
module command_argument_tokenizer_checker #(
    parameter int VALUE_WIDTH = cat_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    cat_char_if  cmd,
    cat_tok_if   tok,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_tokens,
    output int   o_errors,
    output int   o_lines
);
    import cat_pkg::*;

    typedef struct packed {
        logic                   has_byte;
        logic [7:0]             content_byte;
        logic                   token_done;
        logic [1:0]             token_kind;
        logic [VALUE_WIDTH-1:0] int_value;
        logic                   bool_value;
        logic                   error_flag;
        logic [2:0]             error_code;
        logic                   line_done;
    } t_token_result;

    localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
    localparam logic [7:0] TRUE_TEXT [0:7] = '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00};
    localparam logic [7:0] FALSE_TEXT [0:7] = '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00};

    t_mode                  scan_mode;
    logic                   quote_single;
    logic                   escape_pend;
    logic [VALUE_WIDTH-1:0] number_acc;
    logic                   period_seen;
    logic                   overflow_seen;
    logic [2:0]             match_pos;
    logic [1:0]             match_which;
    t_token_result          token_pred;
    t_token_result          expected_tokens [$];
    t_token_result          got;
    t_token_result          want;

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void clear_scan();
        scan_mode     = MODE_IDLE;
        quote_single  = 1'b0;
        escape_pend   = 1'b0;
        number_acc    = '0;
        period_seen   = 1'b0;
        overflow_seen = 1'b0;
        match_pos     = 3'd0;
        match_which   = 2'b11;
    endfunction

    function automatic void latch_error(input logic [2:0] code);
        token_pred.has_byte     = 1'b0;
        token_pred.content_byte = 8'h00;
        token_pred.token_done   = 1'b0;
        token_pred.token_kind   = KIND_STRING;
        token_pred.int_value    = '0;
        token_pred.bool_value   = 1'b0;
        token_pred.error_flag   = 1'b1;
        token_pred.error_code   = code;
        scan_mode               = MODE_SKIP;
    endfunction

    function automatic void close_token(input logic [1:0] kind);
        token_pred.token_done = 1'b1;
        token_pred.token_kind = kind;
        scan_mode             = MODE_IDLE;
    endfunction

    function automatic void close_number();
        if (period_seen) begin
            latch_error(ERR_FLOAT);
        end else if (overflow_seen) begin
            latch_error(ERR_OVERFLOW);
        end else begin
            close_token(KIND_INT);
            token_pred.int_value = number_acc;
        end
    endfunction

    function automatic void close_word();
        if (match_which[0] && match_pos == 3'd4) begin
            close_token(KIND_BOOL);
            token_pred.bool_value = 1'b1;
        end else if (match_which[1] && match_pos == 3'd5) begin
            close_token(KIND_BOOL);
            token_pred.bool_value = 1'b0;
        end else begin
            close_token(KIND_OPTION);
        end
    endfunction

    function automatic void number_step(input logic [7:0] c);
        logic [63:0] acc64;
        logic [63:0] mx64;
        logic [63:0] dgt64;
        if (c == CH_PERIOD) begin
            if (period_seen) latch_error(ERR_TWO_PERIODS);
            else period_seen = 1'b1;
        end else if (is_blank(c)) begin
            close_number();
        end else if (is_decimal(c)) begin
            acc64 = 64'(number_acc);
            mx64  = 64'(VALUE_MAX);
            dgt64 = 64'(c - "0");
            if (acc64 > (mx64 - dgt64) / 64'd10) begin
                overflow_seen = 1'b1;
                number_acc    = VALUE_MAX;
            end else begin
                acc64      = acc64 * 64'd10 + dgt64;
                number_acc = acc64[VALUE_WIDTH-1:0];
            end
        end else begin
            latch_error(ERR_BAD_DIGIT);
        end
    endfunction

    function automatic void word_step(input logic [7:0] c);
        logic [2:0] p;
        p = match_pos;
        token_pred.has_byte     = 1'b1;
        token_pred.content_byte = c;
        if (!(p < 3'd4 && c == TRUE_TEXT[p])) match_which[0] = 1'b0;
        if (!(p < 3'd5 && c == FALSE_TEXT[p])) match_which[1] = 1'b0;
        if (p < POS_MAX) match_pos = p + 3'd1;
    endfunction

    function automatic void scan_char(input logic [7:0] c, input logic last);
        token_pred = '0;
        case (scan_mode)
            MODE_STRING: begin
                if (escape_pend) begin
                    escape_pend             = 1'b0;
                    token_pred.has_byte     = 1'b1;
                    token_pred.content_byte = c;
                end else if (c == CH_BACKSLASH) begin
                    escape_pend = 1'b1;
                end else if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                    close_token(KIND_STRING);
                end else begin
                    token_pred.has_byte     = 1'b1;
                    token_pred.content_byte = c;
                end
            end
            MODE_NUMBER: number_step(c);
            MODE_WORD: begin
                if (is_blank(c)) close_word();
                else word_step(c);
            end
            MODE_SKIP: ;
            default: begin
                if (is_blank(c)) begin
                end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                    scan_mode    = MODE_STRING;
                    quote_single = (c == CH_SQUOTE);
                    escape_pend  = 1'b0;
                end else if (is_decimal(c) || c == CH_PERIOD) begin
                    scan_mode     = MODE_NUMBER;
                    number_acc    = '0;
                    period_seen   = 1'b0;
                    overflow_seen = 1'b0;
                    number_step(c);
                end else if (is_letter(c)) begin
                    scan_mode   = MODE_WORD;
                    match_pos   = 3'd0;
                    match_which = 2'b11;
                    word_step(c);
                end else begin
                    latch_error(ERR_UNEXPECTED);
                end
            end
        endcase
        if (last) begin
            if (scan_mode == MODE_NUMBER) close_number();
            else if (scan_mode == MODE_WORD) close_word();
            else if (scan_mode == MODE_STRING) latch_error(ERR_UNTERMINATED);
            token_pred.line_done = 1'b1;
            clear_scan();
        end
    endfunction

    function automatic string show_result(input t_token_result r);
        return $sformatf("byte %0b/%02h done %0b kind %0d int %0d bool %0b err %0b/%0d line %0b",
                         r.has_byte, r.content_byte, r.token_done, r.token_kind, r.int_value,
                         r.bool_value, r.error_flag, r.error_code, r.line_done);
    endfunction

    task automatic report_mismatch(input string what, input t_token_result exp_r,
                                   input t_token_result got_r);
        $display("[%0t] %s: expected %s | got %s", $time, what, show_result(exp_r),
                 show_result(got_r));
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_scan();
            expected_tokens.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_tokens     = 0;
            o_errors     = 0;
            o_lines      = 0;
        end else begin
            if (tok.valid && tok.ready) begin
                got = {tok.has_byte, tok.content_byte, tok.token_done, tok.token_kind,
                       tok.int_value, tok.bool_value, tok.error_flag, tok.error_code,
                       tok.line_done};
                if (expected_tokens.size() == 0) begin
                    report_mismatch("result with no character pending", '0, got);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) report_mismatch("result differs", want, got);
                    o_tokens += want.token_done;
                    o_errors += want.error_flag;
                    o_lines  += want.line_done;
                end
            end
            if (cmd.valid && cmd.ready) begin
                scan_char(cmd.char_in, cmd.line_end);
                expected_tokens.push_back(token_pred);
            end
            o_pending = expected_tokens.size();
        end
    end

endmodule

// ===== dv/command_argument_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the command argument tokenizer: drives command lines, stalls the
// result channel and gives the verdict. Depends on cat_pkg, cat_if, the tokenizer and the checker.
module command_argument_tokenizer_tb;
    import cat_pkg::*;

    localparam int VW          = VALUE_WIDTH_DEFAULT;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_CHARS = 225;
    localparam int DRAIN_WAIT  = 20;
    localparam logic [7:0] BLANKS [0:5] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    localparam int PHASE_IDLE  [0:3] = '{0, 63, 0, 38};
    localparam int PHASE_STALL [0:3] = '{0, 0, 63, 38};

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   tokens_seen;
    int   errors_seen;
    int   lines_seen;
    int   send_idle;
    int   recv_stall;
    int   chars_sent;
    bit   long_hold_req;
    logic [7:0] line_q [$];

    cat_char_if cmd_ch ();
    cat_tok_if #(.VALUE_WIDTH(VW)) tok_ch ();

    command_argument_tokenizer #(.VALUE_WIDTH(VW)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_tok   (tok_ch)
    );

    command_argument_tokenizer_checker #(.VALUE_WIDTH(VW)) u_token_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .cmd          (cmd_ch),
        .tok          (tok_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_tokens     (tokens_seen),
        .o_errors     (errors_seen),
        .o_lines      (lines_seen)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        tok_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                tok_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
            end
            tok_ch.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_ch.valid && cmd_ch.ready) || (tok_ch.valid && tok_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.char_in  <= c;
        cmd_ch.line_end <= last;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_line();
        for (int k = 0; k < line_q.size(); k++) send_char(line_q[k], k == line_q.size() - 1);
        line_q.delete();
    endtask

    task automatic add_text(input string s);
        for (int k = 0; k < s.len(); k++) line_q.push_back(s[k]);
    endtask

    task automatic add_blanks();
        int n;
        n = $urandom_range(1, 2);
        repeat (n) line_q.push_back($urandom_range(1) ? 8'h20 : BLANKS[$urandom_range(5)]);
    endtask

    task automatic add_digits(input int n);
        repeat (n) line_q.push_back(8'($urandom_range(48, 57)));
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic build_random_line();
        int         n_tok;
        int         pick;
        int         len;
        logic [7:0] q;
        logic [7:0] b;
        n_tok = $urandom_range(1, 4);
        for (int t = 0; t < n_tok; t++) begin
            if ((t > 0 || $urandom_range(3) == 0) && $urandom_range(9) != 0) add_blanks();
            pick = $urandom_range(99);
            if (pick < 25) begin
                q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
                line_q.push_back(q);
                len = $urandom_range(0, 6);
                repeat (len) begin
                    case ($urandom_range(9))
                        0: begin
                            line_q.push_back(CH_BACKSLASH);
                            line_q.push_back(8'($urandom_range(255)));
                        end
                        1: begin
                            line_q.push_back(CH_BACKSLASH);
                            line_q.push_back(q);
                        end
                        default: begin
                            do begin
                                b = $urandom_range(2) != 0 ? 8'($urandom_range(32, 126))
                                                           : 8'($urandom_range(255));
                            end while (b == q || b == CH_BACKSLASH);
                            line_q.push_back(b);
                        end
                    endcase
                end
                if ($urandom_range(9) != 0) line_q.push_back(q);
            end else if (pick < 52) begin
                case ($urandom_range(9))
                    0: add_text("2147483647");
                    1: add_text("2147483648");
                    2: add_digits($urandom_range(10, 13));
                    3: begin
                        add_digits($urandom_range(0, 3));
                        line_q.push_back(CH_PERIOD);
                        add_digits($urandom_range(0, 2));
                        if ($urandom_range(1)) line_q.push_back(CH_PERIOD);
                    end
                    default: add_digits($urandom_range(1, 6));
                endcase
            end else if (pick < 92) begin
                case ($urandom_range(9))
                    0, 1: add_text("true");
                    2, 3: add_text("false");
                    4: begin
                        case ($urandom_range(7))
                            0: add_text("tru");
                            1: add_text("fals");
                            2: add_text("trues");
                            3: add_text("falsee");
                            4: add_text("tRue");
                            5: add_text("False");
                            6: add_text("fa");
                            default: add_text("t");
                        endcase
                    end
                    default: begin
                        line_q.push_back($urandom_range(1) ? 8'($urandom_range(97, 122))
                                                           : 8'($urandom_range(65, 90)));
                        len = $urandom_range(0, 8);
                        repeat (len) begin
                            line_q.push_back($urandom_range(4) != 0 ? 8'($urandom_range(97, 122))
                                                                    : 8'($urandom_range(33, 255)));
                        end
                    end
                endcase
            end else begin
                line_q.push_back(8'($urandom_range(255)));
            end
        end
        if ($urandom_range(4) == 0) add_blanks();
    endtask

    initial begin
        int target;
        cmd_ch.valid    = 1'b0;
        cmd_ch.char_in  = 8'h00;
        cmd_ch.line_end = 1'b0;
        i_rst_n         = 1'b0;
        send_idle       = 0;
        recv_stall      = 0;
        long_hold_req   = 1'b0;
        chars_sent      = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_text("'\\''7 false");
        send_line();
        add_text("\"\\\"b\"true");
        send_line();
        line_q.push_back(8'hFF);
        send_line();
        add_text("..");
        send_line();
        add_text("5a");
        send_line();
        add_text(".");
        send_line();
        add_text("\"");
        send_line();
        add_text("3000000000");
        send_line();
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = PHASE_IDLE[ph];
            recv_stall = PHASE_STALL[ph];
            if (ph == 0) long_hold_req = 1'b1;
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target) begin
                build_random_line();
                send_line();
            end
            drain_results();
        end

        recv_stall = 0;
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (pending != 0) $display("%0d expected results never arrived", pending);
        $display("Sent %0d characters in %0d lines: %0d tokens completed, %0d errors raised.",
                 chars_sent, lines_seen, tokens_seen, errors_seen);
        $display("Ran without idling, with sender gaps, receiver stalls, both, and a long hold-off.");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
